[design/msc_pkg.sv]
`default_nettype none

package msc_pkg;

    localparam int SONG_ENTRIES = 16;
    localparam int IDX_W        = $clog2(SONG_ENTRIES);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_START = 3'd1,
        FUNC_STOP  = 3'd2,
        FUNC_WRITE = 3'd3,
        FUNC_CLEAR = 3'd4
    } func_t;

    localparam logic [1:0] CFG_TICK_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MIDI_CHANNEL  = 2'd1;
    localparam logic [1:0] CFG_CHANGE_LEAD   = 2'd2;

    localparam logic [3:0] CIN_REALTIME = 4'h0F;
    localparam logic [3:0] CIN_PROGRAM  = 4'h0C;
    localparam logic [7:0] ST_CLOCK     = 8'hF8;
    localparam logic [7:0] ST_START     = 8'hFA;
    localparam logic [7:0] ST_STOP      = 8'hFC;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] NO_PROGRAM   = 8'd255;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] entry_index;
        logic [6:0] entry_pattern;
        logic [7:0] entry_length;
        logic [7:0] entry_factor;
    } in_t;

    typedef struct packed {
        logic       msg_valid;
        logic [3:0] code_index;
        logic [7:0] status_byte;
        logic [6:0] data_byte;
        logic       pattern_start;
        logic [3:0] next_index;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [6:0] pattern;
        logic [7:0] length;
        logic [7:0] factor;
    } entry_t;

    typedef struct packed {
        logic   write;
        logic   clear;
        idx_t   addr;
        entry_t data;
    } tbl_wr_t;

    typedef struct packed {
        logic [15:0] tick_interval;
        logic [3:0]  midi_channel;
        logic [7:0]  change_lead;
    } cfg_t;

    typedef struct packed {
        logic [1:0]     count;
        out_t [2:0]     msg;
    } res_t;

endpackage

`default_nettype wire

[design/msc_table.sv]
`default_nettype none

module msc_table (
    input  wire              clk,
    input  wire              rst_n,
    input  msc_pkg::tbl_wr_t wr,
    input  msc_pkg::idx_t    rd_addr,
    output msc_pkg::entry_t  rd_entry,
    output msc_pkg::entry_t  entry0
);
    import msc_pkg::*;

    entry_t mem_reg [SONG_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SONG_ENTRIES; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.clear)
        begin
            for (int i = 0; i < SONG_ENTRIES; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.write)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_entry = mem_reg[rd_addr];
    assign entry0   = mem_reg[0];

endmodule

`default_nettype wire

[design/msc_core.sv]
`default_nettype none

module msc_core (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              go,
    input  msc_pkg::in_t     item,
    input  msc_pkg::cfg_t    cfg,
    input  msc_pkg::entry_t  rd_entry,
    input  msc_pkg::entry_t  entry0,
    output msc_pkg::idx_t    rd_addr,
    output msc_pkg::tbl_wr_t tbl_wr,
    output logic             has_result,
    output msc_pkg::res_t    res
);
    import msc_pkg::*;

    entry_t      cur_reg, cur_next;
    entry_t      upc_reg, upc_next;
    idx_t        playing_reg, playing_next;
    idx_t        upcoming_reg, upcoming_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] clocks_reg, clocks_next;
    logic [7:0]  last_prog_reg, last_prog_next;
    logic        running_reg, running_next;
    logic        start_pend_reg, start_pend_next;
    logic        stop_pend_reg, stop_pend_next;

    logic        run_now;
    entry_t      play_entry;
    logic [15:0] span;
    logic [15:0] clk_inc;
    logic [15:0] lead;
    logic        step_hit;
    logic        end_hit;
    logic        began;
    logic [IDX_W:0] succ;
    idx_t        succ_idx;
    logic        wrap_zero;
    entry_t      step_entry;
    idx_t        step_idx;
    logic [7:0]  last_eff;
    logic        pc_hit;
    idx_t        upcoming_clk;
    entry_t      upc_clk;
    logic [16:0] div_inc;
    logic [15:0] div_wrap;
    logic        wr_in_range;
    idx_t        wr_idx;
    entry_t      new_entry;
    logic [7:0]  prog_status;
    out_t [2:0]  msgs;
    logic [1:0]  count;

    function automatic out_t make_msg(input logic [3:0] code, input logic [7:0] status,
                                      input logic [6:0] data);
        out_t m;
        m               = '0;
        m.msg_valid     = 1'b1;
        m.code_index    = code;
        m.status_byte   = status;
        m.data_byte     = data;
        return m;
    endfunction

    assign has_result = (item.func == FUNC_TICK) && (div_reg == '0);

    // entry timing for this clock
    assign run_now    = start_pend_reg | (running_reg & ~stop_pend_reg);
    assign play_entry = start_pend_reg ? entry0 : cur_reg;
    assign span       = 16'(play_entry.length) * 16'(play_entry.factor);
    assign clk_inc    = clocks_reg + 16'd1;
    assign lead       = 16'(cfg.change_lead);
    assign step_hit   = run_now && (span > lead) && (clk_inc == span - lead);
    assign end_hit    = run_now && (clk_inc >= span);
    assign began      = run_now && (clocks_reg == '0);

    // next table entry, bound checked before the read
    assign succ       = {1'b0, upcoming_reg} + (IDX_W+1)'(1);
    assign succ_idx   = (succ >= (IDX_W+1)'(SONG_ENTRIES)) ? '0 : succ[IDX_W-1:0];
    assign rd_addr    = succ_idx;
    assign wrap_zero  = (rd_entry.length == '0);
    assign step_entry = wrap_zero ? entry0 : rd_entry;
    assign step_idx   = wrap_zero ? '0 : succ_idx;

    assign last_eff     = (start_pend_reg | stop_pend_reg) ? NO_PROGRAM : last_prog_reg;
    assign pc_hit       = step_hit && ({1'b0, step_entry.pattern} != last_eff);
    assign upcoming_clk = step_hit ? step_idx : upcoming_reg;
    assign upc_clk      = step_hit ? step_entry : upc_reg;

    assign div_inc  = {1'b0, div_reg} + 17'd1;
    assign div_wrap = (div_inc >= {1'b0, cfg.tick_interval}) ? '0 : div_inc[15:0];

    assign wr_in_range = 9'(item.entry_index) < 9'(SONG_ENTRIES);
    assign wr_idx      = IDX_W'(item.entry_index);
    assign new_entry   = '{pattern: item.entry_pattern, length: item.entry_length,
                           factor: item.entry_factor};

    assign tbl_wr.write = go && (item.func == FUNC_WRITE) && wr_in_range;
    assign tbl_wr.clear = go && (item.func == FUNC_CLEAR);
    assign tbl_wr.addr  = wr_idx;
    assign tbl_wr.data  = new_entry;

    assign prog_status = ST_PROGRAM | {4'd0, cfg.midi_channel};

    always_comb
    begin
        msgs[0] = make_msg(CIN_REALTIME, ST_CLOCK, '0);
        msgs[1] = '0;
        msgs[2] = '0;
        count   = 2'd1;
        if (start_pend_reg)
        begin
            msgs[1] = make_msg(CIN_REALTIME, ST_START, '0);
            msgs[2] = make_msg(CIN_PROGRAM, prog_status, step_entry.pattern);
            count   = pc_hit ? 2'd3 : 2'd2;
        end
        else if (stop_pend_reg)
        begin
            msgs[1] = make_msg(CIN_REALTIME, ST_STOP, '0);
            msgs[2] = make_msg(CIN_PROGRAM, prog_status, entry0.pattern);
            count   = 2'd3;
        end
        else if (pc_hit)
        begin
            msgs[1] = make_msg(CIN_PROGRAM, prog_status, step_entry.pattern);
            count   = 2'd2;
        end
        for (int k = 0; k < 3; k++)
        begin
            msgs[k].next_index    = 4'(upcoming_clk);
            msgs[k].last          = (2'(k) == count - 2'd1);
            msgs[k].pattern_start = began && (2'(k) == count - 2'd1);
        end
    end

    assign res.count = count;
    assign res.msg   = msgs;

    always_comb
    begin
        cur_next        = cur_reg;
        upc_next        = upc_reg;
        playing_next    = playing_reg;
        upcoming_next   = upcoming_reg;
        div_next        = div_reg;
        clocks_next     = clocks_reg;
        last_prog_next  = last_prog_reg;
        running_next    = running_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        if (go)
        begin
            case (item.func)
                FUNC_TICK:
                begin
                    div_next = div_wrap;
                    if (div_reg == '0)
                    begin
                        if (start_pend_reg)
                        begin
                            start_pend_next = 1'b0;
                            running_next    = 1'b1;
                        end
                        else if (stop_pend_reg)
                        begin
                            stop_pend_next = 1'b0;
                            running_next   = 1'b0;
                        end
                        last_prog_next = pc_hit ? {1'b0, step_entry.pattern} : last_eff;
                        upcoming_next  = upcoming_clk;
                        upc_next       = upc_clk;
                        if (run_now)
                        begin
                            clocks_next = end_hit ? '0 : clk_inc;
                        end
                        if (end_hit)
                        begin
                            playing_next = upcoming_clk;
                            cur_next     = upc_clk;
                        end
                        else if (start_pend_reg)
                        begin
                            playing_next = '0;
                            cur_next     = entry0;
                        end
                    end
                end
                FUNC_START:
                begin
                    start_pend_next = 1'b1;
                end
                FUNC_STOP:
                begin
                    stop_pend_next = 1'b1;
                    upcoming_next  = '0;
                    div_next       = '0;
                    clocks_next    = '0;
                    upc_next       = entry0;
                end
                FUNC_WRITE:
                begin
                    // keep cached entries in step with the table
                    if (wr_in_range && (wr_idx == playing_reg))
                    begin
                        cur_next = new_entry;
                    end
                    if (wr_in_range && (wr_idx == upcoming_reg))
                    begin
                        upc_next = new_entry;
                    end
                end
                FUNC_CLEAR:
                begin
                    cur_next = '0;
                    upc_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            upc_reg        <= '0;
            playing_reg    <= '0;
            upcoming_reg   <= '0;
            div_reg        <= '0;
            clocks_reg     <= '0;
            last_prog_reg  <= NO_PROGRAM;
            running_reg    <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            upc_reg        <= upc_next;
            playing_reg    <= playing_next;
            upcoming_reg   <= upcoming_next;
            div_reg        <= div_next;
            clocks_reg     <= clocks_next;
            last_prog_reg  <= last_prog_next;
            running_reg    <= running_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
        end
    end

endmodule

`default_nettype wire

[design/msc_outbuf.sv]
`default_nettype none

module msc_outbuf (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            load,
    input  msc_pkg::res_t  res,
    output logic           free,
    output logic           result_valid,
    input  wire            result_stall,
    output msc_pkg::out_t  result
);
    import msc_pkg::*;

    out_t [2:0] buf_reg, buf_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop          = (cnt_reg != '0) && !result_stall;
    assign free         = (cnt_reg == '0) || ((cnt_reg == 2'd1) && pop);
    assign result_valid = (cnt_reg != '0);
    assign result       = buf_reg[0];

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = res.msg;
            cnt_next = res.count;
        end
        else if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

`default_nettype wire

[design/midi_song_sequencer_clock.sv]
`default_nettype none

// song-mode midi clock sequencer. every request is registered and handled once
// the output buffer can take its messages; a request may be taken each cycle
// while item_stall is low. a base tick that falls on a midi clock produces one to
// three messages (clock, then start or stop and program change), which leave one
// per cycle while result_stall is low from a three-deep output buffer; the next
// request enters the buffer in the cycle its last message is taken. start, stop,
// entry writes, table clears and ticks between clocks produce no message and never
// wait for the output buffer. the song table sits in flip-flops; a clear empties it.
module midi_song_sequencer_clock (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           item_valid,
    output logic          item_stall,
    input  msc_pkg::in_t  item,
    output logic          result_valid,
    input  wire           result_stall,
    output msc_pkg::out_t result,
    input  wire           cfg_we,
    input  wire [1:0]     cfg_index,
    input  wire [15:0]    cfg_data
);
    import msc_pkg::*;

    in_t     item_reg;
    logic    item_vld_reg;
    cfg_t    cfg_reg;
    logic    advance;
    logic    has_result;
    logic    buf_free;
    res_t    res;
    idx_t    rd_addr;
    tbl_wr_t tbl_wr;
    entry_t  rd_entry;
    entry_t  entry0;

    assign advance    = item_vld_reg && (!has_result || buf_free);
    assign item_stall = item_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_interval <= 16'd1;
            cfg_reg.midi_channel  <= '0;
            cfg_reg.change_lead   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_INTERVAL: cfg_reg.tick_interval <= cfg_data;
                CFG_MIDI_CHANNEL:  cfg_reg.midi_channel  <= cfg_data[3:0];
                CFG_CHANGE_LEAD:   cfg_reg.change_lead   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    msc_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .entry0   (entry0)
    );

    msc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (advance),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .rd_entry   (rd_entry),
        .entry0     (entry0),
        .rd_addr    (rd_addr),
        .tbl_wr     (tbl_wr),
        .has_result (has_result),
        .res        (res)
    );

    msc_outbuf u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && has_result),
        .res          (res),
        .free         (buf_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_start_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.pattern_start || result.last))
        else $error("pattern start flagged on a non-final message");

    a_batch_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("gap inside a message batch");

    a_stop_then_program: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && (result.status_byte == ST_STOP)
        |=> result_valid && (result.code_index == CIN_PROGRAM))
        else $error("stop not followed by program change");
`endif

endmodule

`default_nettype wire

[tb/sv/midi_song_sequencer_clock_tb.sv]
`timescale 1ns / 100ps

module midi_song_sequencer_clock_tb;
    import msc_pkg::*;

    localparam int         CLK_HALF          = 4;
    localparam int         RESET_CYCLES      = 5;
    localparam int         SETTLE_CYCLES     = 4;
    localparam int         DRAIN_CYCLES      = 8;
    localparam int         WATCHDOG_LIMIT    = 2000;
    localparam int         RANDOM_PHASES     = 5;
    localparam int         PHASE_REQUESTS    = 35;
    localparam logic [1:0] CFG_UNUSED        = 2'd3;
    localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    in_t         item;
    logic        result_valid;
    logic        result_stall;
    out_t        result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    midi_song_sequencer_clock dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // sequencer state as the predictor sees it
    logic [6:0]  tbl_pattern [SONG_ENTRIES];
    logic [7:0]  tbl_length  [SONG_ENTRIES];
    logic [7:0]  tbl_factor  [SONG_ENTRIES];
    idx_t        cur_entry;
    idx_t        queued_entry;
    int unsigned tick_phase;
    int unsigned entry_clocks;
    int unsigned sent_program;
    bit          playing;
    bit          start_req;
    bit          stop_req;
    int unsigned interval_reg;
    logic [3:0]  channel_reg;
    int unsigned lead_reg;

    out_t        expected_msgs[$];
    out_t        want;
    int          error_count;
    int          quiet_cycles;
    int          burst_left;
    stall_mode_t stall_mode;
    int          stall_run;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic out_t midi_msg(input logic [3:0] code, input logic [7:0] status,
                                      input logic [6:0] data);
        out_t m;
        m             = '0;
        m.msg_valid   = 1'b1;
        m.code_index  = code;
        m.status_byte = status;
        m.data_byte   = data;
        return m;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SONG_ENTRIES; i++)
        begin
            tbl_pattern[i] = '0;
            tbl_length[i]  = '0;
            tbl_factor[i]  = '0;
        end
    endfunction

    function automatic in_t command(input logic [2:0] func);
        in_t req;
        req      = in_t'($urandom);
        req.func = func;
        return req;
    endfunction

    function automatic in_t entry_write(input logic [3:0] index, input logic [6:0] pattern,
                                        input logic [7:0] length, input logic [7:0] factor);
        in_t req;
        req.func          = FUNC_WRITE;
        req.entry_index   = index;
        req.entry_pattern = pattern;
        req.entry_length  = length;
        req.entry_factor  = factor;
        return req;
    endfunction

    // expected messages for one accepted request
    task automatic predict_request(input in_t req);
        out_t        msgs[$];
        out_t        tail;
        bit          began;
        int unsigned span;
        began = 1'b0;
        case (req.func)
            FUNC_TICK:
            begin
                if (tick_phase == 0)
                begin
                    msgs.push_back(midi_msg(CIN_REALTIME, ST_CLOCK, '0));
                    if (start_req)
                    begin
                        start_req    = 1'b0;
                        playing      = 1'b1;
                        sent_program = 32'(NO_PROGRAM);
                        msgs.push_back(midi_msg(CIN_REALTIME, ST_START, '0));
                        cur_entry    = '0;
                    end
                    else if (stop_req)
                    begin
                        playing      = 1'b0;
                        stop_req     = 1'b0;
                        sent_program = 32'(NO_PROGRAM);
                        msgs.push_back(midi_msg(CIN_REALTIME, ST_STOP, '0));
                        msgs.push_back(midi_msg(CIN_PROGRAM, ST_PROGRAM | {4'h0, channel_reg},
                                                tbl_pattern[0]));
                    end
                    if (playing)
                    begin
                        span  = int'(tbl_length[cur_entry]) * int'(tbl_factor[cur_entry]);
                        began = (entry_clocks == 0);
                        entry_clocks = (entry_clocks + 1) & 16'hFFFF;
                        if (span > lead_reg && entry_clocks == span - lead_reg)
                        begin
                            queued_entry = (int'(queued_entry) + 1 >= SONG_ENTRIES) ? '0
                                                                  : queued_entry + idx_t'(1);
                            if (tbl_length[queued_entry] == 0)
                                queued_entry = '0;
                            if (32'(tbl_pattern[queued_entry]) != sent_program)
                            begin
                                msgs.push_back(midi_msg(CIN_PROGRAM,
                                                        ST_PROGRAM | {4'h0, channel_reg},
                                                        tbl_pattern[queued_entry]));
                                sent_program = 32'(tbl_pattern[queued_entry]);
                            end
                        end
                        if (entry_clocks >= span)
                        begin
                            entry_clocks = 0;
                            cur_entry    = queued_entry;
                        end
                    end
                end
                tick_phase++;
                if (tick_phase >= interval_reg)
                    tick_phase = 0;
                foreach (msgs[k])
                begin
                    tail               = msgs[k];
                    tail.last          = (k == msgs.size() - 1);
                    tail.pattern_start = tail.last && began;
                    tail.next_index    = queued_entry;
                    expected_msgs.push_back(tail);
                end
            end
            FUNC_START:
                start_req = 1'b1;
            FUNC_STOP:
            begin
                stop_req     = 1'b1;
                queued_entry = '0;
                tick_phase   = 0;
                entry_clocks = 0;
            end
            FUNC_WRITE:
            begin
                tbl_pattern[req.entry_index] = req.entry_pattern;
                tbl_length[req.entry_index]  = req.entry_length;
                tbl_factor[req.entry_index]  = req.entry_factor;
            end
            FUNC_CLEAR:
                clear_table();
            default:
                ;
        endcase
    endtask

    task automatic send_request(input in_t req);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                item_valid = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
        burst_left--;
        item       = req;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_request(req);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_valid = 1'b0;
        while (expected_msgs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = 16'($urandom);
        case (index)
            CFG_TICK_INTERVAL: interval_reg = 32'(value);
            CFG_MIDI_CHANNEL:  channel_reg  = value[3:0];
            CFG_CHANGE_LEAD:   lead_reg     = 32'(value[7:0]);
            default:           ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] interval, input logic [3:0] channel,
                                  input logic [7:0] lead);
        logic [15:0] word;
        wait_idle();
        write_register(CFG_TICK_INTERVAL, interval);
        word      = 16'($urandom);
        word[3:0] = channel;
        write_register(CFG_MIDI_CHANNEL, word);
        word      = 16'($urandom);
        word[7:0] = lead;
        write_register(CFG_CHANGE_LEAD, word);
    endtask

    task automatic test_idle_clock();
        send_request(command(FUNC_TICK));
        for (int f = FUNC_FIRST_UNUSED; f <= FUNC_LAST_UNUSED; f++)
            send_request(command(3'(f)));
        send_request(command(FUNC_TICK));
    endtask

    task automatic test_song_playback();
        send_request(entry_write(0, 7'h7F, 8'd1, 8'd1));
        send_request(entry_write(1, 7'h00, 8'd2, 8'd1));
        send_request(entry_write(15, 7'h55, 8'hFF, 8'hFF));
        // zero length entry sends the song back to the top
        send_request(entry_write(2, 7'h7F, 8'd0, 8'hFF));
        send_request(command(FUNC_START));
        send_request(command(FUNC_START));
        repeat (5) send_request(command(FUNC_TICK));
        // start served ahead of stop, stop on the following clock
        send_request(command(FUNC_STOP));
        send_request(command(FUNC_START));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_CLEAR));
        send_request(entry_write(0, 7'h2A, 8'd0, 8'd0));
        send_request(command(FUNC_START));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_STOP));
        send_request(command(FUNC_TICK));
    endtask

    task automatic test_register_extremes();
        apply_settings(16'hFFFF, 4'hF, 8'hFF);
        write_register(CFG_UNUSED, 16'($urandom));
        send_request(command(FUNC_START));
        repeat (6) send_request(command(FUNC_TICK));
        send_request(command(FUNC_STOP));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_TICK));
    endtask

    task automatic test_full_table();
        logic [6:0] pattern;
        apply_settings(16'd1, 4'($urandom), 8'd0);
        send_request(command(FUNC_STOP));
        send_request(command(FUNC_TICK));
        send_request(command(FUNC_CLEAR));
        pattern = 7'($urandom);
        for (int i = 0; i < SONG_ENTRIES; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                pattern = 7'($urandom);
            send_request(entry_write(4'(i), pattern, 8'd1, 8'($urandom_range(1, 2))));
        end
        send_request(command(FUNC_START));
        repeat (40) send_request(command(FUNC_TICK));
    endtask

    task automatic test_random_songs(input int unsigned count);
        int unsigned sent;
        int unsigned song_len;
        int unsigned pick;
        in_t         req;
        sent     = 0;
        song_len = $urandom_range(1, 5);
        for (int i = 0; i < song_len; i++)
        begin
            send_request(entry_write(4'(i), 7'($urandom), 8'($urandom_range(1, 4)),
                                     8'($urandom_range(1, 3))));
            sent++;
        end
        if ($urandom_range(0, 1) == 1)
            send_request(entry_write(4'(song_len), 7'($urandom), 8'd0, 8'($urandom)));
        send_request(command(FUNC_START));
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                req = command(FUNC_TICK);
            else if (pick < 83)
                req = command(FUNC_STOP);
            else if (pick < 89)
                req = command(FUNC_START);
            else if (pick < 95)
                req = entry_write(4'($urandom_range(0, song_len)), 7'($urandom),
                                  8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)));
            else if (pick < 97)
                req = entry_write(4'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 98)
                req = command(FUNC_CLEAR);
            else
                req = command(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)));
            send_request(req);
            if (req.func <= FUNC_CLEAR)
                sent++;
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] expected_value,
                                        input logic [7:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $error("%s: expected %0h, got %0h", name, expected_value, actual_value);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_msgs.size() == 0)
            begin
                $error("message with none expected: %h", result);
                error_count++;
            end
            else
            begin
                want = expected_msgs.pop_front();
                check_field("msg_valid", 8'(want.msg_valid), 8'(result.msg_valid));
                check_field("code_index", 8'(want.code_index), 8'(result.code_index));
                check_field("status_byte", want.status_byte, result.status_byte);
                check_field("data_byte", 8'(want.data_byte), 8'(result.data_byte));
                check_field("pattern_start", 8'(want.pattern_start),
                            8'(result.pattern_start));
                check_field("next_index", 8'(want.next_index), 8'(result.next_index));
                check_field("last", 8'(want.last), 8'(result.last));
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        result_stall = 1'b0;
        stall_run    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_run == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                stall_run  = $urandom_range(8, 60);
            end
            stall_run--;
            case (stall_mode)
                STALL_NONE:  result_stall = 1'b0;
                STALL_LIGHT: result_stall = ($urandom_range(0, 3) == 0);
                default:     result_stall = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        clear_table();
        cur_entry    = '0;
        queued_entry = '0;
        tick_phase   = 0;
        entry_clocks = 0;
        sent_program = 32'(NO_PROGRAM);
        playing      = 1'b0;
        start_req    = 1'b0;
        stop_req     = 1'b0;
        interval_reg = 1;
        channel_reg  = '0;
        lead_reg     = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_clock();
        test_song_playback();
        test_register_extremes();
        test_full_table();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_settings((ph == 0) ? 16'd1 : 16'($urandom_range(1, 3)), 4'($urandom),
                           8'($urandom_range(0, 3)));
            test_random_songs(PHASE_REQUESTS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
design/msc_pkg.sv
design/msc_table.sv
design/msc_core.sv
design/msc_outbuf.sv
design/midi_song_sequencer_clock.sv
tb/sv/midi_song_sequencer_clock_tb.sv
